### sv/unit_weight_shortest_path_top_defines.svh
// ----------------------------------------------------------------------------
// unit weight shortest path: assertion macros
// shared property wrappers for the port checker, clocked on clk, quiet in rst
// ----------------------------------------------------------------------------
`ifndef UNIT_WEIGHT_SHORTEST_PATH_TOP_DEFINES_SVH
`define UNIT_WEIGHT_SHORTEST_PATH_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define UWSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define UWSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/uwsp_pkg.sv
// ----------------------------------------------------------------------------
// uwsp_pkg
// widths, action codes and shared types of the hop distance engine
// ----------------------------------------------------------------------------
package uwsp_pkg;

  localparam int ACTION_W      = 2;
  localparam int NODE_W        = 6;
  localparam int CFG_W         = 7;
  localparam int HOP_W         = 6;
  localparam int DEF_MAX_NODES = 64;

  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EDGE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;
  localparam logic [HOP_W-1:0] HOP_SAT        = 6'd63;

  // adjacency store control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } uwsp_mem_ctl_t;

  // one result word
  typedef struct packed {
    logic [HOP_W-1:0] hop;
    logic             unreach;
  } uwsp_res_t;

endpackage

### sv/unit_weight_shortest_path_top.sv
// ----------------------------------------------------------------------------
// unit_weight_shortest_path_top
// hop distance between two nodes of a small undirected graph
// ----------------------------------------------------------------------------
// The graph lives in an adjacency bit matrix of MAX_NODES rows, with at most
// one row read and one row written per cycle. Per-row valid bits are dropped
// at once on a clear word, so there is no clearing sweep after reset or clear.
// An edge word is a read-modify-write of both rows: read row a, write row a
// while reading row b, then write row b (an edge with an end outside the
// graph is dropped). A query is a level-by-level frontier expansion with the
// single row read port as the shared unit: each level reads every row in use
// once, then merges the last row, leaves the scan and checks the level. A
// query needs as many levels as its answer (all reachable levels plus one
// that finds nothing new when the target is unreachable). Out-of-range or
// equal end nodes answer without a scan. One input word is worked on at a
// time; a finished result sits in the output register so the next word can be
// taken while it waits.
module unit_weight_shortest_path_top #(
  parameter int MAX_NODES = uwsp_pkg::DEF_MAX_NODES
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: node count in use
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uwsp_pkg::CFG_W-1:0]    node_count,
  // command words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [uwsp_pkg::ACTION_W-1:0] action,
  input  logic [uwsp_pkg::NODE_W-1:0]   node_a,
  input  logic [uwsp_pkg::NODE_W-1:0]   node_b,
  // result words, one per query
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [uwsp_pkg::HOP_W-1:0]    hop_count,
  output logic                          unreachable
);
  import uwsp_pkg::*;

  localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  // largest usable node count given the 7-bit register
  localparam int NCAP = (MAX_NODES < 127) ? MAX_NODES : 127;
  localparam logic [CFG_W-1:0] NCAP_V = CFG_W'(NCAP);

  logic [CFG_W-1:0]     nodes_cfg;
  logic [CFG_W-1:0]     n_use;
  logic                 seq_idle;
  logic                 res_valid;
  logic                 res_ready;
  uwsp_res_t            res;
  uwsp_mem_ctl_t        mem_ctl;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [MAX_NODES-1:0] wr_row;
  logic [MAX_NODES-1:0] rd_row;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_cfg <= NODE_COUNT_RST;
    end else if (cfg_valid) begin
      nodes_cfg <= node_count;
    end
  end

  // zero acts as one node, anything beyond the matrix is clipped
  always_comb begin
    priority if (nodes_cfg == '0) begin
      n_use = CFG_W'(1);
    end else if (nodes_cfg > NCAP_V) begin
      n_use = NCAP_V;
    end else begin
      n_use = nodes_cfg;
    end
  end

  // sequencer takes a word only when it has nothing in hand
  assign in_ready = seq_idle;

  // output register, refilled as soon as the old word leaves
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      hop_count   <= res.hop;
      unreachable <= res.unreach;
    end
  end

  uwsp_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .action    (action),
    .node_a    (node_a),
    .node_b    (node_b),
    .n_use     (n_use),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_row    (wr_row),
    .rd_row    (rd_row)
  );

  uwsp_adj_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_adj_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_row  (rd_row)
  );

endmodule

### sv/uwsp_adj_mem.sv
// ----------------------------------------------------------------------------
// uwsp_adj_mem
// adjacency bit matrix, one row per node, with per-row valid bits for clear
// ----------------------------------------------------------------------------
module uwsp_adj_mem #(
  parameter int  MAX_NODES = uwsp_pkg::DEF_MAX_NODES,
  localparam int AW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  uwsp_pkg::uwsp_mem_ctl_t ctl,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           wr_addr,
  input  logic [MAX_NODES-1:0]    wr_row,
  output logic [MAX_NODES-1:0]    rd_row
);
  import uwsp_pkg::*;

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_data;
  logic                 rd_ok;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // a row never written since the last clear reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_ok ? rd_data : '0;

endmodule

### sv/uwsp_seq.sv
// ----------------------------------------------------------------------------
// uwsp_seq
// sequencer for edge updates and level-by-level frontier expansion
// ----------------------------------------------------------------------------
module uwsp_seq #(
  parameter int  MAX_NODES = uwsp_pkg::DEF_MAX_NODES,
  localparam int AW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [uwsp_pkg::ACTION_W-1:0] action,
  input  logic [uwsp_pkg::NODE_W-1:0]   node_a,
  input  logic [uwsp_pkg::NODE_W-1:0]   node_b,
  input  logic [uwsp_pkg::CFG_W-1:0]    n_use,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_ready,
  output uwsp_pkg::uwsp_res_t           res,
  output uwsp_pkg::uwsp_mem_ctl_t       mem_ctl,
  output logic [AW-1:0]                 rd_addr,
  output logic [AW-1:0]                 wr_addr,
  output logic [MAX_NODES-1:0]          wr_row,
  input  logic [MAX_NODES-1:0]          rd_row
);
  import uwsp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_E_RDA = 3'd1;
  localparam logic [2:0] S_E_WRA = 3'd2;
  localparam logic [2:0] S_E_WRB = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_LEVEL = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [MAX_NODES-1:0] ONE_V = (MAX_NODES)'(1);

  logic [2:0]           state;
  logic [NODE_W-1:0]    a_r;
  logic [NODE_W-1:0]    b_r;
  logic [CFG_W-1:0]     idx;
  logic [CFG_W-1:0]     lvl;
  logic [CFG_W-1:0]     lvl_inc;
  logic                 pend;
  logic                 pend_fr;
  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] front;
  logic [MAX_NODES-1:0] nxt;
  logic [MAX_NODES-1:0] use_mask;
  logic                 issue;
  logic                 a_in;
  logic                 b_in;
  uwsp_res_t            res_q;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      use_mask[i] = (i < int'(n_use));
    end
  end

  assign issue   = (idx < n_use);
  assign a_in    = ({1'b0, node_a} < n_use);
  assign b_in    = ({1'b0, node_b} < n_use);
  assign lvl_inc = lvl + 1'b1;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  // memory port steering
  always_comb begin
    mem_ctl   = '0;
    rd_addr   = AW'(a_r);
    wr_addr   = AW'(a_r);
    wr_row    = rd_row | (ONE_V << b_r);
    unique case (state)
      S_IDLE: begin
        mem_ctl.clear_all = start && (action == ACT_CLEAR);
      end
      S_E_RDA: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_E_WRA: begin
        mem_ctl.wr_en = 1'b1;
        mem_ctl.rd_en = 1'b1;
        rd_addr       = AW'(b_r);
      end
      S_E_WRB: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = AW'(b_r);
        wr_row        = rd_row | (ONE_V << a_r);
      end
      S_SCAN: begin
        mem_ctl.rd_en = issue;
        rd_addr       = AW'(idx);
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a_r <= node_a;
            b_r <= node_b;
            if (action == ACT_EDGE) begin
              if (a_in && b_in) begin
                state <= S_E_RDA;
              end
            end else if (action == ACT_QUERY) begin
              res_q.hop <= '0;
              if (!a_in || !b_in) begin
                res_q.unreach <= 1'b1;
                state         <= S_DONE;
              end else if (node_a == node_b) begin
                res_q.unreach <= 1'b0;
                state         <= S_DONE;
              end else begin
                reached <= ONE_V << node_a;
                front   <= ONE_V << node_a;
                nxt     <= '0;
                lvl     <= '0;
                idx     <= '0;
                pend    <= 1'b0;
                state   <= S_SCAN;
              end
            end
          end
        end
        S_E_RDA: state <= S_E_WRA;
        S_E_WRA: state <= S_E_WRB;
        S_E_WRB: state <= S_IDLE;
        S_SCAN: begin
          // read row idx while the row fetched last cycle is merged
          if (issue) begin
            idx     <= idx + 1'b1;
            pend    <= 1'b1;
            pend_fr <= front[AW'(idx)];
          end else begin
            pend <= 1'b0;
          end
          if (pend && pend_fr) begin
            nxt <= nxt | (rd_row & ~reached & use_mask);
          end
          if (!issue && !pend) begin
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (nxt == '0) begin
            res_q.hop     <= '0;
            res_q.unreach <= 1'b1;
            state         <= S_DONE;
          end else if (nxt[AW'(b_r)]) begin
            res_q.hop     <= (lvl_inc > CFG_W'(HOP_SAT)) ? HOP_SAT : lvl_inc[HOP_W-1:0];
            res_q.unreach <= 1'b0;
            state         <= S_DONE;
          end else begin
            reached <= reached | nxt;
            front   <= nxt;
            nxt     <= '0;
            lvl     <= lvl_inc;
            idx     <= '0;
            state   <= S_SCAN;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/uwsp_checker.sv
// ----------------------------------------------------------------------------
// uwsp_checker
// port-level checks on the hop distance engine, bound to the top level
// ----------------------------------------------------------------------------
`include "unit_weight_shortest_path_top_defines.svh"

module uwsp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [uwsp_pkg::ACTION_W-1:0] action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [uwsp_pkg::HOP_W-1:0]    hop_count,
  input logic                          unreachable
);
  import uwsp_pkg::*;

  // a stalled result word holds
  `UWSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hop_count) && $stable(unreachable), "result word changed while stalled")

  // an unreachable answer carries a zero hop count
  `UWSP_ASSERT_NOW(a_unreach_zero, out_valid && unreachable, hop_count == '0, "unreachable result with nonzero hop count")

  // a query word leaves the engine busy: in_ready drops once the word is taken
  `UWSP_ASSERT_NEXT(a_busy_after, in_valid && in_ready && (action == ACT_QUERY), !in_ready, "engine ready right after taking a query word")

endmodule

bind unit_weight_shortest_path_top uwsp_checker u_uwsp_checker (.*);
